// ===== rtl/aocc_pkg.sv =====
package aocc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;
  localparam int COUNT_W  = 8;
  localparam int ACC_W    = 24;
  localparam int DEN_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACC_W-1:0] ACC_POS_MAX = 24'h7FFFFF;
  localparam logic [ACC_W-1:0] ACC_NEG_MIN = 24'h800000;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_SAMPLE  = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_MEASURE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_OFFSET = 2'd1,
    KIND_ACCEL  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LOW  = 2'd0,
    CFG_WINDOW_HIGH = 2'd1,
    CFG_SENSITIVITY = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIN_AXIS,
    ST_DIV_WAIT,
    ST_REPORT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic [1:0]                  axis;
    logic signed [SAMPLE_W-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    kind_t                       kind;
    logic [1:0]                  out_axis;
    logic                        in_window;
    logic signed [ACC_W-1:0]     accel_q16;
    logic signed [SAMPLE_W-1:0]  offset_value;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  window_low;
    logic signed [SAMPLE_W-1:0]  window_high;
    logic [DEN_W-1:0]            sensitivity;
  } cfg_t;

endpackage

// ===== rtl/aocc_div.sv =====
module aocc_div #(
  parameter int NW = 33
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NW-1:0]              num,
  input  logic [aocc_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [NW-1:0]              quo
);
  import aocc_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NW-1:0]     quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              ge;

  // One quotient bit per cycle, restoring division on magnitudes.
  always_comb begin
    rem_sh   = {rem_r, quo_r[NW-1]};
    ge       = rem_sh >= {1'b0, den_r};
    rem_sub  = rem_sh - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NW-2:0], ge};
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a running division");
  a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with an exhausted count");

endmodule

// ===== rtl/aocc_ctrl.sv =====
module aocc_ctrl #(
  parameter int MAX_CAL_SAMPLES = 128,
  parameter int NUM_AXES        = 3,
  parameter int FRAC_BITS       = 16,
  parameter int NW              = 33
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  aocc_pkg::in_item_t         in_data,
  input  aocc_pkg::cfg_t             cfg,
  output logic                       res_valid,
  input  logic                       res_ready,
  output aocc_pkg::out_item_t        res,
  output logic                       div_start,
  output logic [NW-1:0]              div_num,
  output logic [aocc_pkg::DEN_W-1:0] div_den,
  input  logic                       div_done,
  input  logic [NW-1:0]              div_quo
);
  import aocc_pkg::*;

  localparam int AX_IW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int REPORTS = (NUM_AXES < 3) ? NUM_AXES : 3;
  localparam logic [2:0]         NUM_AXES_W = 3'(NUM_AXES);
  localparam logic [AX_IW-1:0]   LAST_AXIS  = AX_IW'(NUM_AXES - 1);
  localparam logic [AX_IW-1:0]   LAST_REP   = AX_IW'(REPORTS - 1);
  localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(MAX_CAL_SAMPLES);

  state_t                      state_r, state_nxt;
  cmd_t                        cmd_r, cmd_nxt;
  logic [1:0]                  ax_r, ax_nxt;
  logic signed [SAMPLE_W-1:0]  sample_r, sample_nxt;
  logic [AX_IW-1:0]            idx_r, idx_nxt;
  logic                        neg_r, neg_nxt;
  out_item_t                   res_r, res_nxt;

  logic signed [SUM_W-1:0]     cal_sum_r [NUM_AXES];
  logic signed [SUM_W-1:0]     cal_sum_nxt [NUM_AXES];
  logic [COUNT_W-1:0]          cal_count_r [NUM_AXES];
  logic [COUNT_W-1:0]          cal_count_nxt [NUM_AXES];
  logic signed [SAMPLE_W-1:0]  axis_offset_r [NUM_AXES];
  logic signed [SAMPLE_W-1:0]  axis_offset_nxt [NUM_AXES];

  logic                        in_accept;
  logic                        ax_valid;
  logic                        inwin;
  logic signed [SUM_W-1:0]     sum_rd;
  logic [COUNT_W-1:0]          count_rd;
  logic signed [SAMPLE_W-1:0]  offset_rd;
  logic signed [SAMPLE_W:0]    diff;
  logic [SAMPLE_W:0]           diff_mag;
  logic [SUM_W-1:0]            sum_mag;
  logic [SAMPLE_W-1:0]         q_off;
  logic [ACC_W-1:0]            acc_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign res_valid = (state_r == ST_EMIT);
  assign res       = res_r;

  always_comb begin
    ax_valid  = {1'b0, ax_r} < NUM_AXES_W;
    inwin     = (sample_r > cfg.window_low) && (sample_r < cfg.window_high);
    sum_rd    = cal_sum_r[idx_r];
    count_rd  = cal_count_r[idx_r];
    offset_rd = axis_offset_r[idx_r];
    diff      = {sample_r[SAMPLE_W-1], sample_r} - {offset_rd[SAMPLE_W-1], offset_rd};
    diff_mag  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    sum_mag   = sum_rd[SUM_W-1] ? (~sum_rd + 1'b1) : sum_rd;
    q_off     = neg_r ? (~div_quo[SAMPLE_W-1:0] + 1'b1) : div_quo[SAMPLE_W-1:0];
    if (!neg_r) begin
      acc_sat = (div_quo > NW'(ACC_POS_MAX)) ? ACC_POS_MAX : div_quo[ACC_W-1:0];
    end else begin
      acc_sat = (div_quo > NW'(ACC_NEG_MIN)) ? ACC_NEG_MIN
                                             : (~div_quo[ACC_W-1:0] + 1'b1);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    ax_nxt          = ax_r;
    sample_nxt      = sample_r;
    idx_nxt         = idx_r;
    neg_nxt         = neg_r;
    res_nxt         = res_r;
    cal_sum_nxt     = cal_sum_r;
    cal_count_nxt   = cal_count_r;
    axis_offset_nxt = axis_offset_r;
    div_start       = 1'b0;
    div_num         = '0;
    div_den         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_nxt    = in_data.cmd;
          ax_nxt     = in_data.axis;
          sample_nxt = in_data.sample;
          idx_nxt    = in_data.axis[AX_IW-1:0];
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_nxt = '{kind: KIND_ACK, out_axis: ax_r, in_window: 1'b0,
                    accel_q16: '0, offset_value: '0, last: 1'b1};
        state_nxt = ST_EMIT;
        case (cmd_r)
          CMD_CLEAR: begin
            res_nxt.out_axis = '0;
            for (int i = 0; i < NUM_AXES; i++) begin
              cal_sum_nxt[i]   = '0;
              cal_count_nxt[i] = '0;
            end
          end
          CMD_SAMPLE: begin
            if (ax_valid && inwin && (count_rd < MAX_COUNT)) begin
              cal_sum_nxt[idx_r]   = sum_rd + {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
              cal_count_nxt[idx_r] = count_rd + 1'b1;
              res_nxt.in_window    = 1'b1;
            end
          end
          CMD_FINISH: begin
            idx_nxt   = '0;
            state_nxt = ST_FIN_AXIS;
          end
          CMD_MEASURE: begin
            res_nxt.kind = KIND_ACCEL;
            if (ax_valid) begin
              res_nxt.offset_value = offset_rd;
              if (inwin) begin
                res_nxt.in_window = 1'b1;
                if (diff != '0) begin
                  div_start = 1'b1;
                  div_num   = {diff_mag, {FRAC_BITS{1'b0}}};
                  div_den   = cfg.sensitivity;
                  neg_nxt   = diff[SAMPLE_W];
                  state_nxt = ST_DIV_WAIT;
                end
              end
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_FIN_AXIS: begin
        if (count_rd == '0) begin
          axis_offset_nxt[idx_r] = '0;
          if (idx_r == LAST_AXIS) begin
            idx_nxt   = '0;
            state_nxt = ST_REPORT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          div_start = 1'b1;
          div_num   = NW'(sum_mag);
          div_den   = DEN_W'(count_rd);
          neg_nxt   = sum_rd[SUM_W-1];
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (cmd_r == CMD_FINISH) begin
            axis_offset_nxt[idx_r] = q_off;
            if (idx_r == LAST_AXIS) begin
              idx_nxt   = '0;
              state_nxt = ST_REPORT;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = ST_FIN_AXIS;
            end
          end else begin
            res_nxt.accel_q16 = acc_sat;
            state_nxt         = ST_EMIT;
          end
        end
      end
      ST_REPORT: begin
        res_nxt = '{kind: KIND_OFFSET, out_axis: 2'(idx_r), in_window: 1'b0,
                    accel_q16: '0, offset_value: offset_rd,
                    last: (idx_r == LAST_REP)};
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready) begin
          if ((cmd_r == CMD_FINISH) && !res_r.last) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_REPORT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < NUM_AXES; i++) begin
        cal_sum_r[i]     <= '0;
        cal_count_r[i]   <= '0;
        axis_offset_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      cal_sum_r     <= cal_sum_nxt;
      cal_count_r   <= cal_count_nxt;
      axis_offset_r <= axis_offset_nxt;
    end
    cmd_r    <= cmd_nxt;
    ax_r     <= ax_nxt;
    sample_r <= sample_nxt;
    idx_r    <= idx_nxt;
    neg_r    <= neg_nxt;
    res_r    <= res_nxt;
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_DECODE)
    else $error("accepted item not decoded");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT)
    else $error("division finished outside of wait state");
  a_out_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_r.in_window) |-> res_r.accel_q16 == '0)
    else $error("acceleration reported for a rejected sample");

endmodule

// ===== rtl/accel_offset_calibrate_convert.sv =====
// Channel  Ports                          Direction  Item
// input    in_valid, in_stall, in_data    in         command, axis, sample
// result   out_valid, out_stall, out_data out        kind, axis, window, accel, offset, last
// config   cfg_valid, cfg_ready, cfg_*    in         register index and data
//
// A measure uses the divider only for an in-window sample that differs from the
// offset; a finish divides once per axis with samples, skips empty axes and then
// emits the offset reports. Both share the one-bit-per-cycle divider.
// Reset is synchronous; it restores the register defaults and clears all sums,
// counts and offsets. A stalled result waits in the output register while the
// next item is accepted.
module accel_offset_calibrate_convert #(
  parameter int MAX_CAL_SAMPLES = 128,
  parameter int NUM_AXES        = 3,
  parameter int FRAC_BITS       = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  aocc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output aocc_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aocc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aocc_pkg::DEN_W-1:0]     cfg_data
);
  import aocc_pkg::*;

  localparam int NW = SAMPLE_W + 1 + FRAC_BITS;

  cfg_t             cfg_r, cfg_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             res_valid;
  logic             res_ready;
  out_item_t        res;
  logic             div_start;
  logic [NW-1:0]    div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NW-1:0]    div_quo;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_LOW:  cfg_nxt.window_low  = cfg_data;
        CFG_WINDOW_HIGH: cfg_nxt.window_high = cfg_data;
        CFG_SENSITIVITY: cfg_nxt.sensitivity = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_low  <= 16'sd7000;
      cfg_r.window_high <= 16'sd16000;
      cfg_r.sensitivity <= 16'd2434;
      out_valid_r       <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  aocc_ctrl #(
    .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES),
    .NUM_AXES        (NUM_AXES),
    .FRAC_BITS       (FRAC_BITS),
    .NW              (NW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo)
  );

  aocc_div #(
    .NW (NW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule
